// ----- rtl/core/sli_pkg.sv -----
// shared types and constants for the sorted table block
// no dependencies; used by the controller, the datapath and the top level
`timescale 1ns / 1ps

package sli_pkg;

  // table geometry
  localparam int CAPACITY   = 64;
  localparam int VALUE_BITS = 32;
  localparam int COUNT_BITS = $clog2(CAPACITY + 1);

  // operation kinds
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_DELETE = 1'b1;

  // result status codes
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  // request transaction
  typedef struct packed {
    logic                         kind;
    logic signed [VALUE_BITS-1:0] value;
  } item_t;

  // result transaction
  typedef struct packed {
    logic [1:0]                   status;
    logic [COUNT_BITS-1:0]        entry_count;
    logic                         has_entries;
    logic signed [VALUE_BITS-1:0] smallest;
    logic signed [VALUE_BITS-1:0] largest;
  } result_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic compare;
    logic update;
    logic report;
  } cmd_t;

endpackage

// ----- rtl/core/sli_ctrl.sv -----
// sequencing state machine for the sorted table block
// depends on sli_pkg; drives the command struct of sli_datapath
`timescale 1ns / 1ps

module sli_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output sli_pkg::cmd_t cmd
);
  import sli_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_COMPARE = 4'b0010,
    S_UPDATE  = 4'b0100,
    S_REPORT  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next  = state;
    cmd.load    = 1'b0;
    cmd.compare = 1'b0;
    cmd.update  = 1'b0;
    cmd.report  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_COMPARE;
        end
      end
      S_COMPARE: begin
        cmd.compare = 1'b1;
        state_next  = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_REPORT;
      end
      S_REPORT: begin
        cmd.report = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

// ----- rtl/core/sli_datapath.sv -----
// row of compare-and-shift cells holding the sorted table, plus result register
// depends on sli_pkg; commanded by sli_ctrl
`timescale 1ns / 1ps

module sli_datapath (
  input  logic             clk,
  input  logic             rst,
  input  sli_pkg::cmd_t    cmd,
  input  sli_pkg::item_t   item,
  output sli_pkg::result_t result,
  output logic             done
);
  import sli_pkg::*;

  // cell storage, valid bits form a prefix of the row
  logic signed [VALUE_BITS-1:0] entries [CAPACITY];
  logic [CAPACITY-1:0]          valid;
  logic [COUNT_BITS-1:0]        count;

  // latched request
  logic                         kind;
  logic signed [VALUE_BITS-1:0] key;

  // registered compare results
  logic [CAPACITY-1:0] open;
  logic [CAPACITY-1:0] ge;
  logic                found;
  logic [1:0]          status;

  logic [CAPACITY-1:0]          open_next;
  logic [CAPACITY-1:0]          ge_next;
  logic [CAPACITY-1:0]          eq_vec;
  logic [CAPACITY-1:0]          last;
  logic signed [VALUE_BITS-1:0] largest_sel;

  // per-cell comparators against the key
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      open_next[i] = !valid[i] || (entries[i] > key);
      ge_next[i]   = valid[i] && (entries[i] >= key);
      eq_vec[i]    = valid[i] && (entries[i] == key);
    end
  end

  // last occupied cell and its value
  always_comb begin
    largest_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (i == CAPACITY - 1) begin
        last[i] = valid[i];
      end else begin
        last[i] = valid[i] && !valid[(i < CAPACITY - 1) ? i + 1 : i];
      end
      largest_sel = largest_sel | (entries[i] & {VALUE_BITS{last[i]}});
    end
  end

  // request latch and compare flags
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind <= item.kind;
      key  <= item.value;
    end
    if (cmd.compare) begin
      open  <= open_next;
      ge    <= ge_next;
      found <= |eq_vec;
    end
  end

  // cell shifting: insert moves the upper part up, delete pulls it down
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      if (kind == KIND_INSERT) begin
        if (!valid[CAPACITY-1]) begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (open[i]) begin
              if (i > 0 && open[(i > 0) ? i - 1 : 0]) begin
                entries[i] <= entries[(i > 0) ? i - 1 : 0];
              end else begin
                entries[i] <= key;
              end
            end
          end
        end
      end else begin
        if (valid[0] && found) begin
          for (int i = 0; i < CAPACITY - 1; i++) begin
            if (ge[i]) begin
              entries[i] <= entries[i+1];
            end
          end
        end
      end
    end
  end

  // occupancy and status
  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      count  <= '0;
      status <= ST_DONE;
    end else if (cmd.update) begin
      if (kind == KIND_INSERT) begin
        if (valid[CAPACITY-1]) begin
          status <= ST_FULL;
        end else begin
          valid  <= {valid[CAPACITY-2:0], 1'b1};
          count  <= count + COUNT_BITS'(1);
          status <= ST_DONE;
        end
      end else begin
        if (!valid[0]) begin
          status <= ST_EMPTY;
        end else if (found) begin
          valid  <= {1'b0, valid[CAPACITY-1:1]};
          count  <= count - COUNT_BITS'(1);
          status <= ST_DONE;
        end else begin
          status <= ST_NOT_FOUND;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.report) begin
      result.status      <= status;
      result.entry_count <= count;
      result.has_entries <= valid[0];
      result.smallest    <= valid[0] ? entries[0] : '0;
      result.largest     <= largest_sel;
    end
  end

  // one-cycle result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.report;
    end
  end

endmodule

// ----- rtl/core/sorted_list_insert_delete_top.sv -----
// A request is taken when start is high and busy is low, and each request
// goes through load, one parallel compare across all 64 table cells, one
// shift of the cells, and the result register. The result is loaded into
// result as done goes high for exactly one cycle and cannot be held off; the next
// request may start in the cycle that done is high. The table holds up to
// 64 signed 32-bit values in ascending order, no clearing pass after reset.
// Top level of the sorted table block; depends on sli_pkg, sli_ctrl and
// sli_datapath.
`timescale 1ns / 1ps

module sorted_list_insert_delete_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  sli_pkg::item_t   item,
  output sli_pkg::result_t result,
  output logic             done
);
  import sli_pkg::*;

  cmd_t cmd;

  // sequencer
  sli_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // cell row and result register
  sli_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .item   (item),
    .result (result),
    .done   (done)
  );

endmodule
